// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers, switched out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/rtdlin_pkg.sv -----
package rtdlin_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAULT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [4:0] OP_NONE = 5'd0;
    localparam logic [4:0] OP_LOAD = 5'd1;
    localparam logic [4:0] OP_MRES = 5'd2;
    localparam logic [4:0] OP_RES  = 5'd3;
    localparam logic [4:0] OP_MW   = 5'd4;
    localparam logic [4:0] OP_W    = 5'd5;
    localparam logic [4:0] OP_SQ   = 5'd6;
    localparam logic [4:0] OP_DSQ  = 5'd7;
    localparam logic [4:0] OP_M1   = 5'd8;
    localparam logic [4:0] OP_E1   = 5'd9;
    localparam logic [4:0] OP_MULR = 5'd10;
    localparam logic [4:0] OP_E2   = 5'd11;
    localparam logic [4:0] OP_E3   = 5'd12;
    localparam logic [4:0] OP_E4   = 5'd13;
    localparam logic [4:0] OP_QQ   = 5'd14;
    localparam logic [4:0] OP_QE   = 5'd15;
    localparam logic [4:0] OP_QM   = 5'd16;
    localparam logic [4:0] OP_QC   = 5'd17;
    localparam logic [4:0] OP_CHK  = 5'd18;
    localparam logic [4:0] OP_OUT  = 5'd19;

    localparam logic [15:0] REF_RESET   = 16'd27520;
    localparam logic [15:0] RES_R0      = 16'd6400;
    localparam logic [47:0] K_B         = 48'd231000000;
    localparam logic [63:0] K_W0        = 64'd9775877689600;
    localparam logic [59:0] K_SQ_OFFS   = 60'd800420764;
    localparam logic [31:0] K_RCP_QUAD  = 32'd148743457;
    localparam logic [47:0] K_C4        = 48'd28183;
    localparam logic [47:0] K_C3        = 48'd308864000;
    localparam logic [47:0] K_C2        = 48'd10591846400000;
    localparam logic [47:0] K_C1        = 48'd2222800000000;
    localparam logic [63:0] K_C0_BIASED = 64'd4510970000000000;
    localparam logic [59:0] K_DIV_QUART = 60'd500000000000;
    localparam logic [31:0] K_RCP_QUART = 32'd2361183241;
    localparam logic [31:0] K_QUART_D5  = 32'd244140625;
    localparam logic [20:0] K_QUART_OFFS = 21'd40000;
    localparam logic signed [20:0] T_MIN = -21'sd25600;
    localparam logic signed [20:0] T_MAX = 21'sd108800;
    localparam logic [4:0]  SQ_STEPS    = 5'd29;

    typedef struct packed {
        logic [4:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic fault;
        logic res_high;
        logic w_neg;
        logic cnt_zero;
    } dp_flags_t;

endpackage

// ----- sv/rtdlin_ctrl.sv -----
module rtdlin_ctrl
    import rtdlin_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dp_flags_t flags,
    output dp_cmd_t   cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MRES = 5'd1;
    localparam logic [4:0] S_RES  = 5'd2;
    localparam logic [4:0] S_MW   = 5'd3;
    localparam logic [4:0] S_W    = 5'd4;
    localparam logic [4:0] S_SQ   = 5'd5;
    localparam logic [4:0] S_DSQ  = 5'd6;
    localparam logic [4:0] S_M1   = 5'd7;
    localparam logic [4:0] S_E1   = 5'd8;
    localparam logic [4:0] S_MR2  = 5'd9;
    localparam logic [4:0] S_E2   = 5'd10;
    localparam logic [4:0] S_MR3  = 5'd11;
    localparam logic [4:0] S_E3   = 5'd12;
    localparam logic [4:0] S_MR4  = 5'd13;
    localparam logic [4:0] S_E4   = 5'd14;
    localparam logic [4:0] S_QQ   = 5'd15;
    localparam logic [4:0] S_QE   = 5'd16;
    localparam logic [4:0] S_QM   = 5'd17;
    localparam logic [4:0] S_QC   = 5'd18;
    localparam logic [4:0] S_CHK  = 5'd19;
    localparam logic [4:0] S_OUT  = 5'd20;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = flags.fault ? S_OUT : S_MRES;
                end
            end
            S_MRES:
            begin
                cmd.op     = OP_MRES;
                state_next = S_RES;
            end
            S_RES:
            begin
                cmd.op     = OP_RES;
                state_next = flags.res_high ? S_MW : S_M1;
            end
            S_MW:
            begin
                cmd.op     = OP_MW;
                state_next = S_W;
            end
            S_W:
            begin
                cmd.op     = OP_W;
                state_next = flags.w_neg ? S_OUT : S_SQ;
            end
            S_SQ:
            begin
                cmd.op = OP_SQ;
                if (flags.cnt_zero)
                begin
                    state_next = S_DSQ;
                end
            end
            S_DSQ:
            begin
                cmd.op     = OP_DSQ;
                state_next = S_QQ;
            end
            S_QQ:
            begin
                cmd.op     = OP_QQ;
                state_next = S_CHK;
            end
            S_M1:
            begin
                cmd.op     = OP_M1;
                state_next = S_E1;
            end
            S_E1:
            begin
                cmd.op     = OP_E1;
                state_next = S_MR2;
            end
            S_MR2:
            begin
                cmd.op     = OP_MULR;
                state_next = S_E2;
            end
            S_E2:
            begin
                cmd.op     = OP_E2;
                state_next = S_MR3;
            end
            S_MR3:
            begin
                cmd.op     = OP_MULR;
                state_next = S_E3;
            end
            S_E3:
            begin
                cmd.op     = OP_E3;
                state_next = S_MR4;
            end
            S_MR4:
            begin
                cmd.op     = OP_MULR;
                state_next = S_E4;
            end
            S_E4:
            begin
                cmd.op     = OP_E4;
                state_next = S_QE;
            end
            S_QE:
            begin
                cmd.op     = OP_QE;
                state_next = S_QM;
            end
            S_QM:
            begin
                cmd.op     = OP_QM;
                state_next = S_QC;
            end
            S_QC:
            begin
                cmd.op     = OP_QC;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.op     = OP_CHK;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/rtdlin_dp.sv -----
module rtdlin_dp
    import rtdlin_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic [15:0]        rtd_word,
    input  dp_cmd_t            cmd,
    output dp_flags_t          flags,
    output logic signed [17:0] temperature,
    output logic [15:0]        resistance,
    output logic [14:0]        raw_code,
    output logic [1:0]         status
);

    logic [15:0]        ref_reg;
    logic signed [17:0] held_reg;
    logic [14:0]        code_reg;
    logic [15:0]        res_reg;
    logic [1:0]         stat_reg;
    logic               quart_reg;
    logic [63:0]        prod_reg;
    logic [47:0]        acc_reg;
    logic [59:0]        sq_v_reg, sq_root_reg, sq_bit_reg;
    logic [59:0]        rem_reg, qd_reg;
    logic [19:0]        q_reg;
    logic [4:0]         cnt_reg;

    logic [15:0]        mul_a;
    logic [47:0]        mul_b;
    logic [27:0]        dv_a;
    logic [31:0]        dv_b;
    logic [59:0]        dv_prod;
    logic [15:0]        res_new;
    logic [63:0]        w_full;
    logic [59:0]        sq_sum;
    logic signed [20:0] t_val;
    logic               t_ok;

    assign res_new = prod_reg[30:15];
    assign w_full  = K_W0 - prod_reg;
    assign sq_sum  = sq_root_reg + sq_bit_reg;
    assign dv_prod = {32'd0, dv_a} * {28'd0, dv_b};
    assign t_val   = quart_reg ? $signed({1'b0, q_reg} - K_QUART_OFFS)
                               : $signed({1'b0, q_reg});
    assign t_ok    = (t_val >= T_MIN) && (t_val <= T_MAX);

    assign flags.fault    = rtd_word[0];
    assign flags.res_high = (res_new >= RES_R0);
    assign flags.w_neg    = (prod_reg > K_W0);
    assign flags.cnt_zero = (cnt_reg == 5'd0);

    always_comb
    begin
        case (cmd.op)
            OP_MRES:
            begin
                mul_a = {1'b0, code_reg};
                mul_b = {32'd0, ref_reg};
            end
            OP_MW:
            begin
                mul_a = res_reg - RES_R0;
                mul_b = K_B;
            end
            OP_M1:
            begin
                mul_a = res_reg;
                mul_b = K_C4;
            end
            default:
            begin
                mul_a = res_reg;
                mul_b = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            OP_QQ:
            begin
                dv_a = rem_reg[30:3];
                dv_b = K_RCP_QUAD;
            end
            OP_QE:
            begin
                dv_a = rem_reg[54:27];
                dv_b = K_RCP_QUART;
            end
            default:
            begin
                dv_a = {11'd0, q_reg[16:0]};
                dv_b = K_QUART_D5;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg  <= REF_RESET;
            held_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ref_reg <= cfg_wr_data;
            end
            if (cmd.op == OP_CHK && t_ok)
            begin
                held_reg <= t_val[17:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                code_reg <= rtd_word[15:1];
                res_reg  <= '0;
                stat_reg <= rtd_word[0] ? ST_FAULT : ST_OK;
            end
            OP_MRES, OP_MW, OP_M1, OP_MULR:
            begin
                prod_reg <= {32'd0, mul_a} * {16'd0, mul_b};
            end
            OP_RES:
            begin
                res_reg   <= res_new;
                quart_reg <= (res_new < RES_R0);
            end
            OP_W:
            begin
                stat_reg    <= (prod_reg > K_W0) ? ST_RANGE : ST_OK;
                sq_v_reg    <= {w_full[43:0], 16'd0};
                sq_root_reg <= '0;
                sq_bit_reg  <= 60'd1 << 58;
                cnt_reg     <= SQ_STEPS;
            end
            OP_SQ:
            begin
                if (sq_v_reg >= sq_sum)
                begin
                    sq_v_reg    <= sq_v_reg - sq_sum;
                    sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_root_reg <= sq_root_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg - 5'd1;
            end
            OP_DSQ:
            begin
                rem_reg <= K_SQ_OFFS - sq_root_reg;
            end
            OP_QQ:
            begin
                q_reg <= dv_prod[54:35];
            end
            OP_E1:
            begin
                acc_reg <= K_C3 - prod_reg[47:0];
            end
            OP_E2:
            begin
                acc_reg <= K_C2 + prod_reg[47:0];
            end
            OP_E3:
            begin
                acc_reg <= K_C1 + {2'd0, prod_reg[63:18]};
            end
            OP_E4:
            begin
                rem_reg <= prod_reg[59:0] + K_C0_BIASED[59:0];
            end
            OP_QE:
            begin
                q_reg <= {3'd0, dv_prod[59:43]};
            end
            OP_QM:
            begin
                qd_reg <= dv_prod;
            end
            OP_QC:
            begin
                if (rem_reg >= (qd_reg << 11) + K_DIV_QUART)
                begin
                    q_reg <= q_reg + 20'd1;
                end
            end
            OP_CHK:
            begin
                stat_reg <= t_ok ? ST_OK : ST_RANGE;
            end
            OP_OUT:
            begin
                temperature <= held_reg;
                resistance  <= res_reg;
                raw_code    <= code_reg;
                status      <= stat_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- sv/rtd_temperature_linearizer.sv -----
// Channel | Handshake                  | Payload
// input   | in_valid / in_ready        | rtd_word
// output  | out_valid / out_ready      | temperature, resistance, raw_code, status
// config  | cfg_wr_en                  | cfg_wr_data
// One request at a time: fault words go from the accept straight to the output step,
// the quadratic path runs the 30-step square root (skipped on a negative radicand),
// and quotients come from reciprocal multiplies, with one fix-up on the quartic path.
// A result waits in the output register; the next request is taken meanwhile,
// and a stalled output holds only the final step.
// Reset clears the held temperature and loads the reference resistance.
`include "assert_macros.svh"

module rtd_temperature_linearizer
    import rtdlin_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        rtd_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [17:0] temperature,
    output logic [15:0]        resistance,
    output logic [14:0]        raw_code,
    output logic [1:0]         status
);

    dp_cmd_t   cmd;
    dp_flags_t flags;
    logic      t_in_range;

    assign t_in_range = (temperature >= -18'sd25600) && (temperature <= 18'sd108800);

    rtdlin_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    rtdlin_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rtd_word    (rtd_word),
        .cmd         (cmd),
        .flags       (flags),
        .temperature (temperature),
        .resistance  (resistance),
        .raw_code    (raw_code),
        .status      (status)
    );

    `ASSERT_IMPL(a_fault_res, clk, rst_n, out_valid && status == ST_FAULT, resistance == 16'd0)
    `ASSERT_IMPL(a_ok_in_range, clk, rst_n, out_valid && status == ST_OK, t_in_range)
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready)

endmodule

// ----- tb/sv/testbench.sv -----
module testbench
    import rtdlin_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    class reading_board;
        logic [15:0]        ref_ohms;
        logic signed [17:0] held_temp;
        logic signed [17:0] q_temp[$];
        logic [15:0]        q_res[$];
        logic [14:0]        q_code[$];
        logic [1:0]         q_status[$];
        int                 errors;

        function void clear();
            ref_ohms = REF_RESET;
            held_temp = '0;
            errors = 0;
        endfunction

        function longint unsigned root64(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_word(logic [15:0] word);
            logic [14:0]     code;
            logic [15:0]     res;
            logic [1:0]      st;
            longint          t;
            longint          w;
            longint          e1;
            longint          e2;
            longint          e3;
            longint          e4;
            longint          r;
            longint unsigned s;
            bit              ok;
            code = word[15:1];
            res = '0;
            if (word[0])
                st = ST_FAULT;
            else
            begin
                res = 16'((longint'(code) * longint'(ref_ohms)) >> 15);
                ok = 1'b1;
                t = 0;
                if (res >= 16'd6400)
                begin
                    w = 64'sd9775877689600 - 64'sd231000000 * (longint'(res) - 6400);
                    if (w < 0)
                        ok = 1'b0;
                    else
                    begin
                        s = root64(longint'(unsigned'(w)) << 16);
                        t = longint'((64'd800420764 - s) / 64'd1848);
                    end
                end
                else
                begin
                    r = longint'(res);
                    e1 = 64'sd308864000 - 64'sd28183 * r;
                    e2 = 64'sd2585900000 * 4096 + r * e1;
                    e3 = (64'sd2222800000000 * 262144 + r * e2) / 262144;
                    e4 = -64'sd242020000000000 * 64 + r * e3;
                    t = longint'((unsigned'(e4 + 64'sd20000000000000000 + 64'sd250000000000))
                        / 64'd500000000000) - 40000;
                end
                if (ok && t >= -25600 && t <= 108800)
                begin
                    held_temp = 18'(t);
                    st = ST_OK;
                end
                else
                    st = ST_RANGE;
            end
            q_temp.push_back(held_temp);
            q_res.push_back(res);
            q_code.push_back(code);
            q_status.push_back(st);
        endfunction

        function void check_result(logic signed [17:0] temp, logic [15:0] res,
                                   logic [14:0] code, logic [1:0] st);
            if (q_temp.size() == 0)
            begin
                $error("unexpected result");
                errors++;
                return;
            end
            if (temp !== q_temp[0])
            begin
                $error("temperature exp %0d got %0d", q_temp[0], temp);
                errors++;
            end
            if (res !== q_res[0])
            begin
                $error("resistance exp %0d got %0d", q_res[0], res);
                errors++;
            end
            if (code !== q_code[0])
            begin
                $error("raw_code exp %0d got %0d", q_code[0], code);
                errors++;
            end
            if (st !== q_status[0])
            begin
                $error("status exp %0d got %0d", q_status[0], st);
                errors++;
            end
            void'(q_temp.pop_front());
            void'(q_res.pop_front());
            void'(q_code.pop_front());
            void'(q_status.pop_front());
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [15:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic [15:0]        rtd_word;
    logic               out_valid;
    logic               out_ready;
    logic signed [17:0] temperature;
    logic [15:0]        resistance;
    logic [14:0]        raw_code;
    logic [1:0]         status;

    reading_board board;
    int           cycles;
    int           burst_left;
    int           stall_mode;

    rtd_temperature_linearizer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rtd_word    (rtd_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .temperature (temperature),
        .resistance  (resistance),
        .raw_code    (raw_code),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 1500000)
            begin
                $display("[rtd_temperature_linearizer] ERROR");
                $finish;
            end
        end
    end

    // receiver stall pattern: free-running, periodic, and random phases
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(temperature, resistance, raw_code, status);
            if ((cycles % 600) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ((cycles % 7) < 3);
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic send_word(input logic [15:0] word);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rtd_word <= word;
        board.note_word(word);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.q_temp.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_ref(input logic [15:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        board.ref_ohms = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_word();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'($urandom);
        if (k == 1)
            return {15'($urandom), 1'b1};
        return {15'($urandom_range(4000, 16000)), 1'b0};
    endfunction

    initial
    begin
        logic [15:0] settings[6];
        board = new();
        board.clear();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        rtd_word = '0;
        out_ready = 1'b0;
        stall_mode = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'hFFFE);
        send_word(16'h0001);
        send_word(16'hAAAA);
        send_word(16'h5554);
        send_word({15'd7620, 1'b0});
        send_word({15'd7621, 1'b0});
        send_word({15'd9000, 1'b0});
        send_word({15'd15000, 1'b0});
        send_word({15'd26000, 1'b0});
        send_word({15'd1800, 1'b0});
        send_word({15'd100, 1'b0});
        send_word({15'd6000, 1'b0});

        settings = '{16'd65535, 16'd0, 16'd27520, 16'd32000, 16'd12800, 16'd50000};
        foreach (settings[i])
        begin
            write_ref(settings[i]);
            send_word(16'hFFFE);
            send_word(16'h8000);
            repeat (330) send_word(pick_word());
        end
        drain();
        if (board.errors == 0 && board.q_temp.size() == 0)
            $display("[rtd_temperature_linearizer] OK");
        else
            $display("[rtd_temperature_linearizer] ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/rtdlin_pkg.sv
sv/rtdlin_ctrl.sv
sv/rtdlin_dp.sv
sv/rtd_temperature_linearizer.sv
tb/sv/testbench.sv
